>>> src/rshd_pkg.sv
// types and constants for the ray/segment hit distance pipeline
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package rshd_pkg;

   localparam int unsigned DIST_W = 16;
   localparam int unsigned QUO_W = 17;
   localparam int unsigned NUM_W = 34;
   localparam int unsigned DEN_W = 33;

   typedef struct packed {
      logic signed [15:0] ray_x;
      logic signed [15:0] ray_y;
      logic signed [15:0] ray_dx;
      logic signed [15:0] ray_dy;
      logic signed [15:0] seg_x;
      logic signed [15:0] seg_y;
      logic signed [15:0] seg_dx;
      logic signed [15:0] seg_dy;
      logic [15:0]        seg_len;
   } req_word_type;

   typedef struct packed {
      logic              hit;
      logic [DIST_W-1:0] hit_dist;
   } rsp_word_type;

   // division job: nd and den positive magnitudes, hit decided
   typedef struct packed {
      logic             hit;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } div_job_type;

endpackage
`default_nettype wire

>>> src/rshd_det.sv
// determinant and range-test front end, three register stages
// depends on rshd_pkg
`timescale 1ns / 1ps
`default_nettype none
module rshd_det import rshd_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         adv,
   input  wire logic         in_valid,
   input  req_word_type      in_word,
   output logic              out_valid,
   output div_job_type       out_job
);

   // stage 1: differences and products
   logic                v1_ff;
   logic signed [32:0]  a1_ff, b1_ff, c1_ff, d1_ff, e1_ff, f1_ff;
   logic [15:0]         len1_ff;
   logic signed [16:0]  px, py;

   assign px = 17'(in_word.seg_x) - 17'(in_word.ray_x);
   assign py = 17'(in_word.seg_y) - 17'(in_word.ray_y);

   // stage 2: determinants, sign fix
   logic                v2_ff;
   logic signed [34:0]  den2_ff, nd2_ff, ns2_ff;
   logic [15:0]         len2_ff;
   logic signed [34:0]  den_s, nd_s, ns_s;

   assign den_s = 35'(a1_ff) - 35'(b1_ff);
   assign nd_s  = 35'(c1_ff) - 35'(d1_ff);
   assign ns_s  = 35'(e1_ff) - 35'(f1_ff);

   // stage 3: length compare
   logic [48:0] lhs, rhs;
   logic        hit3;

   assign lhs = {ns2_ff[34:0], 14'b0};
   assign rhs = 49'(len2_ff) * 49'(den2_ff[32:0]);
   assign hit3 = (den2_ff != '0) && !nd2_ff[34] && !ns2_ff[34] && (lhs <= rhs);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         out_valid <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         out_valid <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a1_ff <= 33'(in_word.ray_dx) * 33'(in_word.seg_dy);
         b1_ff <= 33'(in_word.ray_dy) * 33'(in_word.seg_dx);
         c1_ff <= 33'(px) * 33'(in_word.seg_dy);
         d1_ff <= 33'(py) * 33'(in_word.seg_dx);
         e1_ff <= 33'(px) * 33'(in_word.ray_dy);
         f1_ff <= 33'(py) * 33'(in_word.ray_dx);
         len1_ff <= in_word.seg_len;
         if (den_s < 0) begin
            den2_ff <= -den_s;
            nd2_ff  <= -nd_s;
            ns2_ff  <= -ns_s;
         end else begin
            den2_ff <= den_s;
            nd2_ff  <= nd_s;
            ns2_ff  <= ns_s;
         end
         len2_ff <= len1_ff;
         out_job.hit <= hit3;
         out_job.num <= NUM_W'(nd2_ff);
         out_job.den <= DEN_W'(den2_ff);
      end
   end

endmodule
`default_nettype wire

>>> src/rshd_div.sv
// pipelined restoring divider, one quotient bit per stage, saturating
// depends on rshd_pkg
`timescale 1ns / 1ps
`default_nettype none
module rshd_div import rshd_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    adv,
   input  wire logic    in_valid,
   input  div_job_type  in_job,
   output logic         out_valid,
   output rsp_word_type out_word
);

   // quotient q = floor(num*2^14/den), only 17 bits needed to saturate
   // prescreen: q >= 2^17 iff num*2^14 >= den*2^17 iff num >= den*8
   localparam int unsigned RW = DEN_W + 1;

   logic              v_ff   [QUO_W+1];
   logic              hit_ff [QUO_W+1];
   logic              sat_ff [QUO_W+1];
   logic [RW-1:0]     rem_ff [QUO_W+1];
   logic [DEN_W-1:0]  den_ff [QUO_W+1];
   logic [47:0]       dvd_ff [QUO_W+1];
   logic [QUO_W-1:0]  q_ff   [QUO_W+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= QUO_W; i++) v_ff[i] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= in_valid;
         for (int i = 1; i <= QUO_W; i++) v_ff[i] <= v_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hit_ff[0] <= in_job.hit;
         sat_ff[0] <= (DEN_W+3)'(in_job.num) >= {in_job.den, 3'b0};
         den_ff[0] <= in_job.den;
         dvd_ff[0] <= {in_job.num, 14'b0};
         rem_ff[0] <= '0;
         q_ff[0]   <= '0;
         for (int i = 1; i <= QUO_W; i++) begin
            hit_ff[i] <= hit_ff[i-1];
            sat_ff[i] <= sat_ff[i-1];
            den_ff[i] <= den_ff[i-1];
            dvd_ff[i] <= dvd_ff[i-1];
         end
      end
   end

   // stage i produces quotient bit QUO_W-i; remainder fed from dividend top bits
   for (genvar g = 1; g <= QUO_W; g++) begin : g_step
      logic [RW:0] sh;
      logic [RW:0] diff;
      always_comb begin
         if (g == 1) begin
            sh = (RW+1)'(dvd_ff[0][47:QUO_W-1]);
         end else begin
            sh = {rem_ff[g-1], dvd_ff[g-1][QUO_W-g]};
         end
         diff = sh - (RW+1)'(den_ff[g-1]);
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            if (!diff[RW]) begin
               rem_ff[g] <= diff[RW-1:0];
               q_ff[g]   <= {q_ff[g-1][QUO_W-2:0], 1'b1};
            end else begin
               rem_ff[g] <= sh[RW-1:0];
               q_ff[g]   <= {q_ff[g-1][QUO_W-2:0], 1'b0};
            end
         end
      end
   end

   assign out_valid = v_ff[QUO_W];
   always_comb begin
      out_word.hit = hit_ff[QUO_W];
      if (!hit_ff[QUO_W]) out_word.hit_dist = '0;
      else if (sat_ff[QUO_W] || q_ff[QUO_W][QUO_W-1]) out_word.hit_dist = '1;
      else out_word.hit_dist = q_ff[QUO_W][DIST_W-1:0];
   end

endmodule
`default_nettype wire

>>> src/ray_segment_hit_distance.sv
// req word to rsp word: 3 det stages, 1 divider input reg, 17 div stages, out reg
// throughput: one word per cycle unless rsp_stall backs up; divider is one bit per stage
// reset clears all valid bits; no stored state beyond the pipeline
// depends on rshd_pkg, rshd_det, rshd_div
`timescale 1ns / 1ps
`default_nettype none
module ray_segment_hit_distance import rshd_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   req_valid,
   output logic        req_stall,
   input  req_word_type req_word,
   output logic        rsp_valid,
   input  wire logic   rsp_stall,
   output rsp_word_type rsp_word
);

   logic         adv;
   logic         dv;
   div_job_type  job;
   logic         qv;
   rsp_word_type qw;

   // pipeline moves when output register free or being taken
   assign adv = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   rshd_det u_det (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(req_valid), .in_word(req_word),
      .out_valid(dv), .out_job(job)
   );

   rshd_div u_div (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(dv), .in_job(job),
      .out_valid(qv), .out_word(qw)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (adv) begin
         rsp_valid <= qv;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) rsp_word <= qw;
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("rsp word changed while stalled");
   a_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.hit |-> rsp_word.hit_dist == '0)
      else $error("miss with nonzero distance");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output backpressure");

endmodule
`default_nettype wire
